/* rtl/core/idle_load_per_subframe_monitor_assert.svh */
// Assertion macros used by the idle-load monitor top level.
`ifndef IDLE_LOAD_PER_SUBFRAME_MONITOR_ASSERT_SVH
`define IDLE_LOAD_PER_SUBFRAME_MONITOR_ASSERT_SVH

// Checked on every clock edge outside reset.
`define ILM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Also skips the first edge after reset is released.
`define ILM_ASSERT_STEADY(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) $past(rst_n) |-> (expr)) \
    else $error(msg);

`endif

/* rtl/core/ilm_pkg.sv */
// Package for the idle-load monitor: widths, defaults, beat and control types.
package ilm_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int FS_W           = 10;
  localparam int SF_W           = 8;
  localparam int TIME_W         = 16;

  localparam logic [FS_W-1:0] FULL_SCALE_RST = 10'd100;

  typedef struct packed {
    logic [SF_W-1:0]   subframe_index;
    logic [TIME_W-1:0] time_in_frame;
  } in_beat_t;

  typedef struct packed {
    logic [FS_W-1:0]   idle_ms;
    logic [TIME_W-1:0] frame_time;
    logic [SF_W-1:0]   finished_subframe;
  } out_beat_t;

  // Sequencer -> scale unit
  typedef struct packed {
    logic start;
  } scale_ctl_t;

  // Scale unit -> sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } scale_sts_t;

endpackage

/* rtl/core/idle_load_per_subframe_monitor.sv */
// Top level of the idle-load monitor: tick counting, sequencer, output register.
// Usage:
//   Input channel (in_valid/in_stall/in_data): one beat per idle-loop tick,
//   carrying the running subframe index and the time in frame.
//   Output channel (out_valid/out_stall/out_data): one beat per subframe
//   boundary with the idle share of the finished subframe, scaled to
//   full_scale, plus the boundary time and the finished subframe index.
//   cfg_we/cfg_wdata write full_scale; write it only while the block is idle.
// Timing:
//   A tick inside a subframe is accepted without a stall; in_stall stays low.
//   A boundary tick holds in_stall high through these steps: start is passed
//   and the product formed, one load, 10 quotient steps of the restoring
//   divider, done handed back, and the move into the output register.
//   out_valid rises with that last step; a result still stalled in the
//   output register adds its wait to both.
// Reset: the tick count, maximum and the seen-a-subframe flag clear; full_scale
//   returns to 100. The first tick records its subframe and is counted too.
// Back-pressure: a waiting result sits in the output register while plain
//   ticks keep flowing; a second boundary result waits for it to drain.
`include "idle_load_per_subframe_monitor_assert.svh"
module idle_load_per_subframe_monitor #(
  parameter int COUNT_BITS = ilm_pkg::COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  ilm_pkg::in_beat_t        in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output ilm_pkg::out_beat_t       out_data,
  input  logic                     cfg_we,
  input  logic [ilm_pkg::FS_W-1:0] cfg_wdata
);

  localparam int FS_W   = ilm_pkg::FS_W;
  localparam int SF_W   = ilm_pkg::SF_W;
  localparam int TIME_W = ilm_pkg::TIME_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [COUNT_BITS-1:0]  tick_r, tick_nxt;
  logic [COUNT_BITS-1:0]  max_r, max_nxt;
  logic [COUNT_BITS-1:0]  hold_r, hold_nxt;
  logic [SF_W-1:0]        prev_sf_r, prev_sf_nxt;
  logic                   prev_vld_r, prev_vld_nxt;
  logic [SF_W-1:0]        fin_sf_r, fin_sf_nxt;
  logic [TIME_W-1:0]      time_r, time_nxt;
  logic [FS_W-1:0]        fs_r, fs_nxt;
  logic                   start_r, start_nxt;
  logic                   out_valid_r, out_valid_nxt;
  ilm_pkg::out_beat_t     out_data_r, out_data_nxt;

  logic                   in_fire;
  logic                   boundary;
  logic [COUNT_BITS-1:0]  tick_inc;
  logic                   out_free;
  logic [FS_W-1:0]        idle_val;

  ilm_pkg::scale_ctl_t    sc_ctl;
  ilm_pkg::scale_sts_t    sc_sts;
  logic [FS_W-1:0]        sc_quot;

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  // saturating tick count, current tick included
  assign tick_inc = (tick_r == CNT_MAX) ? tick_r : tick_r + 1'b1;
  assign boundary = prev_vld_r && (in_data.subframe_index != prev_sf_r);
  assign out_free = !out_valid_r || !out_stall;
  // quotient cannot pass full_scale since count <= max; clamp kept as a guard
  assign idle_val = (sc_quot > fs_r) ? fs_r : sc_quot;

  assign sc_ctl.start = start_r;

  ilm_scale #(
    .COUNT_BITS (COUNT_BITS)
  ) u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (sc_ctl),
    .count (hold_r),
    .top   (max_r),
    .scale (fs_r),
    .sts   (sc_sts),
    .quot  (sc_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    max_nxt       = max_r;
    hold_nxt      = hold_r;
    prev_sf_nxt   = prev_sf_r;
    prev_vld_nxt  = prev_vld_r;
    fin_sf_nxt    = fin_sf_r;
    time_nxt      = time_r;
    fs_nxt        = cfg_we ? cfg_wdata : fs_r;
    start_nxt     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          prev_sf_nxt  = in_data.subframe_index;
          prev_vld_nxt = 1'b1;
          if (boundary) begin
            tick_nxt   = '0;
            max_nxt    = (tick_inc > max_r) ? tick_inc : max_r;
            hold_nxt   = tick_inc;
            fin_sf_nxt = prev_sf_r;
            time_nxt   = in_data.time_in_frame;
            start_nxt  = 1'b1;
            state_nxt  = ST_CALC;
          end else begin
            tick_nxt = tick_inc;
          end
        end
      end
      ST_CALC: begin
        if (sc_sts.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.idle_ms         = idle_val;
          out_data_nxt.frame_time      = time_r;
          out_data_nxt.finished_subframe = fin_sf_r;
          state_nxt                    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      max_r       <= '0;
      prev_sf_r   <= '0;
      prev_vld_r  <= 1'b0;
      fs_r        <= ilm_pkg::FULL_SCALE_RST;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      max_r       <= max_nxt;
      prev_sf_r   <= prev_sf_nxt;
      prev_vld_r  <= prev_vld_nxt;
      fs_r        <= fs_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r     <= hold_nxt;
    fin_sf_r   <= fin_sf_nxt;
    time_r     <= time_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a new result only comes out of the emit state
  `ILM_ASSERT(a_out_from_emit, $rose(out_valid_r) |-> $past(state_r == ST_EMIT), "result without emit")
  // count restarts after every boundary beat
  `ILM_ASSERT(a_tick_clear, (in_fire && boundary) |=> (tick_r == '0), "tick count not cleared")
  // divider finishes only while the sequencer waits for it
  `ILM_ASSERT(a_done_in_calc, sc_sts.done |-> (state_r == ST_CALC), "divider done out of turn")
  // running maximum never drops
  `ILM_ASSERT_STEADY(a_max_mono, max_r >= $past(max_r), "maximum decreased")
  // divisor always covers the dividend count handed to the unit
  `ILM_ASSERT(a_hold_le_max, (state_r == ST_CALC) |-> (hold_r <= max_r), "count above maximum")
  // input stays closed while the divider works
  `ILM_ASSERT(a_busy_stall, sc_sts.busy |-> in_stall, "input open while divider busy")

endmodule

/* rtl/core/ilm_scale.sv */
// Iterative scale unit: count * scale / top, one quotient bit per cycle.
module ilm_scale #(
  parameter int COUNT_BITS = ilm_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ilm_pkg::scale_ctl_t        ctl,
  input  logic [COUNT_BITS-1:0]      count,
  input  logic [COUNT_BITS-1:0]      top,
  input  logic [ilm_pkg::FS_W-1:0]   scale,
  output ilm_pkg::scale_sts_t        sts,
  output logic [ilm_pkg::FS_W-1:0]   quot
);

  localparam int FS_W   = ilm_pkg::FS_W;
  localparam int PROD_W = COUNT_BITS + FS_W;
  localparam int STEP_W = $clog2(FS_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FS_W - 1);

  typedef enum logic [2:0] {
    SC_IDLE = 3'b001,
    SC_LOAD = 3'b010,
    SC_DIV  = 3'b100
  } sc_state_t;

  sc_state_t             state_r, state_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [COUNT_BITS-1:0] div_r, div_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [FS_W-1:0]       lo_r, lo_nxt;
  logic [FS_W-1:0]       q_r, q_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  done_r, done_nxt;

  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;

  // Restoring step: bring down the next product bit, subtract if it fits.
  // The high part of the product is already below the divisor because
  // count <= top and scale < 2^FS_W, so FS_W steps give the full quotient.
  assign trial = {rem_r, lo_r[FS_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = (trial >= {1'b0, div_r});

  always_comb begin
    state_nxt = state_r;
    prod_nxt  = prod_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    lo_nxt    = lo_r;
    q_nxt     = q_r;
    step_nxt  = step_r;
    done_nxt  = 1'b0;
    case (state_r)
      SC_IDLE: begin
        if (ctl.start) begin
          prod_nxt  = {{FS_W{1'b0}}, count} * {{COUNT_BITS{1'b0}}, scale};
          div_nxt   = top;
          state_nxt = SC_LOAD;
        end
      end
      SC_LOAD: begin
        rem_nxt   = prod_r[PROD_W-1:FS_W];
        lo_nxt    = prod_r[FS_W-1:0];
        q_nxt     = '0;
        step_nxt  = '0;
        state_nxt = SC_DIV;
      end
      SC_DIV: begin
        rem_nxt  = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
        q_nxt    = {q_r[FS_W-2:0], ge};
        lo_nxt   = {lo_r[FS_W-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          done_nxt  = 1'b1;
          state_nxt = SC_IDLE;
        end
      end
      default: begin
        state_nxt = SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    lo_r   <= lo_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
  end

  assign sts.busy = (state_r != SC_IDLE);
  assign sts.done = done_r;
  assign quot     = q_r;

endmodule
